// ===== src/fsq_pkg.sv =====
// Shared constants, types and the sequencer program of the four-square decomposition block.
package fsq_pkg;

	localparam int TARGET_BITS = 24;
	localparam int ROOT_BITS = (TARGET_BITS + 1) / 2;
	localparam int CNT_W = ROOT_BITS + 1;
	localparam int SQ_W = 2 * ROOT_BITS + 1;
	localparam int SUM_W = 2 * ROOT_BITS + 3;
	localparam int SQRT_W = 2 * ROOT_BITS;
	localparam int ITER_W = $clog2(ROOT_BITS);
	localparam int ITER_LAST = ROOT_BITS - 1;

	localparam int IN_W = 24;
	localparam int ROOT_FIELD_W = 12;
	localparam int LAST_FIELD_W = 13;
	localparam int OUT_DATA_W = 56;

	typedef enum logic [3:0] {
		STEP_IDLE,
		STEP_A_CHECK,
		STEP_B_CHECK,
		STEP_C_CHECK,
		STEP_SQRT,
		STEP_TEST,
		STEP_A_NEXT,
		STEP_B_NEXT,
		STEP_DONE
	} step_t;

	typedef enum logic [2:0] {
		COND_ALWAYS,
		COND_IN_VALID,
		COND_A_LT,
		COND_B_LT,
		COND_C_OK,
		COND_SQRT_LAST,
		COND_REM_ZERO,
		COND_OUT_FREE
	} cond_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_CLR_B,
		OP_CLR_C,
		OP_SQRT_INIT,
		OP_SQRT_STEP,
		OP_SET_HIT,
		OP_INC_A,
		OP_INC_B,
		OP_INC_C,
		OP_EMIT
	} op_t;

	typedef struct packed {
		cond_t cond;
		op_t   op_true;
		step_t next_true;
		op_t   op_false;
		step_t next_false;
	} ctrl_t;

	function automatic ctrl_t ucode(input step_t step);
		ctrl_t w;
		w = '{COND_ALWAYS, OP_NONE, STEP_IDLE, OP_NONE, STEP_IDLE};
		case (step)
			STEP_IDLE:    w = '{COND_IN_VALID, OP_LOAD, STEP_A_CHECK, OP_NONE, STEP_IDLE};
			STEP_A_CHECK: w = '{COND_A_LT, OP_CLR_B, STEP_B_CHECK, OP_NONE, STEP_DONE};
			STEP_B_CHECK: w = '{COND_B_LT, OP_CLR_C, STEP_C_CHECK, OP_NONE, STEP_A_NEXT};
			STEP_C_CHECK: w = '{COND_C_OK, OP_SQRT_INIT, STEP_SQRT, OP_NONE, STEP_B_NEXT};
			STEP_SQRT:    w = '{COND_SQRT_LAST, OP_SQRT_STEP, STEP_TEST,
				OP_SQRT_STEP, STEP_SQRT};
			STEP_TEST:    w = '{COND_REM_ZERO, OP_SET_HIT, STEP_DONE, OP_INC_C, STEP_C_CHECK};
			STEP_A_NEXT:  w = '{COND_ALWAYS, OP_INC_A, STEP_A_CHECK, OP_INC_A, STEP_A_CHECK};
			STEP_B_NEXT:  w = '{COND_ALWAYS, OP_INC_B, STEP_B_CHECK, OP_INC_B, STEP_B_CHECK};
			STEP_DONE:    w = '{COND_OUT_FREE, OP_EMIT, STEP_IDLE, OP_NONE, STEP_DONE};
			default:      w = '{COND_ALWAYS, OP_NONE, STEP_IDLE, OP_NONE, STEP_IDLE};
		endcase
		return w;
	endfunction

endpackage

// ===== src/four_square_decomposition.sv =====
// Microcoded search that splits one target into four squares.
// Run time is data dependent: a candidate triple with a non-negative remainder runs the full
// bit-serial square root, and each pass of the middle or outer loop adds its checks and
// advance; loading and delivering follow, plus any m_tready wait.
// One transaction is processed at a time; the next is taken while a result waits.
// Reset clears the step counter and the output valid flag.
module four_square_decomposition (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // [23:0] target
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,  // [11:0] first_root, [23:12] second_root,
	                              // [35:24] third_root, [48:36] fourth_root, rest zero
	output logic        m_tuser   // [0] found
);

	fsq_pkg::step_t pc_q, pc_next;
	fsq_pkg::ctrl_t ctrl;
	fsq_pkg::op_t   op;
	logic           cond_ok;

	logic [fsq_pkg::TARGET_BITS-1:0] n_q;
	logic [fsq_pkg::CNT_W-1:0]       a_q, b_q, c_q;
	logic [fsq_pkg::SQ_W-1:0]        a2_q, b2_q, c2_q;
	logic [fsq_pkg::SQRT_W-1:0]      v_q, r_q, bit_q;
	logic [fsq_pkg::ITER_W-1:0]      iter_q;
	logic                            hit_q;
	logic                            out_valid_q;

	logic [fsq_pkg::SUM_W-1:0]  n_ext, sum_abc, rem;
	logic [fsq_pkg::SQRT_W-1:0] trial;
	logic                       a_lt, b_lt, c_ok, out_free;

	assign n_ext    = fsq_pkg::SUM_W'(n_q);
	assign sum_abc  = fsq_pkg::SUM_W'(a2_q) + fsq_pkg::SUM_W'(b2_q) + fsq_pkg::SUM_W'(c2_q);
	assign rem      = n_ext - sum_abc;
	assign a_lt     = fsq_pkg::SUM_W'(a2_q) < n_ext;
	assign b_lt     = fsq_pkg::SUM_W'(b2_q) < n_ext;
	assign c_ok     = (fsq_pkg::SUM_W'(c2_q) < n_ext) && (sum_abc <= n_ext);
	assign trial    = r_q + bit_q;
	assign out_free = !out_valid_q || m_tready;

	assign ctrl = fsq_pkg::ucode(pc_q);

	always_comb begin
		case (ctrl.cond)
			fsq_pkg::COND_ALWAYS:    cond_ok = 1'b1;
			fsq_pkg::COND_IN_VALID:  cond_ok = s_tvalid;
			fsq_pkg::COND_A_LT:      cond_ok = a_lt;
			fsq_pkg::COND_B_LT:      cond_ok = b_lt;
			fsq_pkg::COND_C_OK:      cond_ok = c_ok;
			fsq_pkg::COND_SQRT_LAST: cond_ok = (iter_q == fsq_pkg::ITER_W'(fsq_pkg::ITER_LAST));
			fsq_pkg::COND_REM_ZERO:  cond_ok = (v_q == '0);
			fsq_pkg::COND_OUT_FREE:  cond_ok = out_free;
			default:                 cond_ok = 1'b0;
		endcase
	end

	always_comb begin
		pc_next = cond_ok ? ctrl.next_true : ctrl.next_false;
	end

	always_comb begin
		op       = cond_ok ? ctrl.op_true : ctrl.op_false;
		s_tready = (pc_q == fsq_pkg::STEP_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= fsq_pkg::STEP_IDLE;
		end else begin
			pc_q <= pc_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (op == fsq_pkg::OP_EMIT) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			fsq_pkg::OP_LOAD: begin
				n_q   <= fsq_pkg::TARGET_BITS'(s_tdata);
				a_q   <= '0;
				a2_q  <= '0;
				hit_q <= 1'b0;
			end
			fsq_pkg::OP_CLR_B: begin
				b_q  <= '0;
				b2_q <= '0;
			end
			fsq_pkg::OP_CLR_C: begin
				c_q  <= '0;
				c2_q <= '0;
			end
			fsq_pkg::OP_SQRT_INIT: begin
				v_q    <= fsq_pkg::SQRT_W'(rem);
				r_q    <= '0;
				bit_q  <= fsq_pkg::SQRT_W'(1) << (fsq_pkg::SQRT_W - 2);
				iter_q <= '0;
			end
			fsq_pkg::OP_SQRT_STEP: begin
				if (v_q >= trial) begin
					v_q <= v_q - trial;
					r_q <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q  <= bit_q >> 2;
				iter_q <= iter_q + fsq_pkg::ITER_W'(1);
			end
			fsq_pkg::OP_SET_HIT: begin
				hit_q <= 1'b1;
			end
			fsq_pkg::OP_INC_A: begin
				a_q  <= a_q + fsq_pkg::CNT_W'(1);
				a2_q <= a2_q + fsq_pkg::SQ_W'({a_q, 1'b1});
			end
			fsq_pkg::OP_INC_B: begin
				b_q  <= b_q + fsq_pkg::CNT_W'(1);
				b2_q <= b2_q + fsq_pkg::SQ_W'({b_q, 1'b1});
			end
			fsq_pkg::OP_INC_C: begin
				c_q  <= c_q + fsq_pkg::CNT_W'(1);
				c2_q <= c2_q + fsq_pkg::SQ_W'({c_q, 1'b1});
			end
			fsq_pkg::OP_EMIT: begin
				if (hit_q) begin
					m_tdata <= fsq_pkg::OUT_DATA_W'({fsq_pkg::LAST_FIELD_W'(r_q),
						fsq_pkg::ROOT_FIELD_W'(c_q), fsq_pkg::ROOT_FIELD_W'(b_q),
						fsq_pkg::ROOT_FIELD_W'(a_q)});
				end else begin
					m_tdata <= '0;
				end
				m_tuser <= hit_q;
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = out_valid_q;

endmodule
